// ===== hdl/demand_paging_fault_resolver_assert.svh =====
// Assertion macros for the demand paging fault resolver
`ifndef DEMAND_PAGING_FAULT_RESOLVER_ASSERT_SVH
`define DEMAND_PAGING_FAULT_RESOLVER_ASSERT_SVH

// same-cycle implication, sampled on clock, disabled during reset
`define DPFR_ASSERT_SAME(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication, sampled on clock, disabled during reset
`define DPFR_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== hdl/dpfr_pkg.sv =====
// Package with constants, codes and shared types of the demand paging fault resolver
`default_nettype none

package dpfr_pkg;

   localparam int MAX_SEGMENTS      = 8;
   localparam int PAGES_PER_SEGMENT = 256;
   localparam int PAGE_BYTES        = 4096;

   localparam int ADDR_W   = 32;
   localparam int IDX_W    = 3;
   localparam int ACCESS_W = 3;
   localparam int COPY_W   = 13;
   localparam int CSR_W    = 4;

   localparam int SEG_W      = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int CNT_W      = $clog2(MAX_SEGMENTS + 1);
   localparam int PAGE_W     = (PAGES_PER_SEGMENT > 1) ? $clog2(PAGES_PER_SEGMENT) : 1;
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int ROW_W      = PAGES_PER_SEGMENT;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_FAULT = 1'b1;

   typedef enum logic [1:0] {
      OUT_LOADED  = 2'd0,
      OUT_MAP     = 2'd1,
      OUT_FORWARD = 2'd2,
      OUT_MAPPED  = 2'd3
   } outcome_type;

   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   typedef struct packed {
      alu_op_type        op;
      logic [ADDR_W-1:0] a;
      logic [ADDR_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] sum;
      logic              borrow;
   } alu_rsp_type;

   typedef struct packed {
      logic             en;
      logic [SEG_W-1:0] row;
      logic [ROW_W-1:0] data;
   } map_wr_type;

endpackage

`default_nettype wire

// ===== hdl/dpfr_if.sv =====
// Request and response channel interfaces of the demand paging fault resolver
`default_nettype none

interface dpfr_req_if;
   import dpfr_pkg::*;

   logic                valid;
   logic                ready;
   logic                func;
   logic [IDX_W-1:0]    seg_index;
   logic [ADDR_W-1:0]   seg_base;
   logic [ADDR_W-1:0]   seg_mem_bytes;
   logic [ADDR_W-1:0]   seg_file_bytes;
   logic [ADDR_W-1:0]   seg_file_start;
   logic [ACCESS_W-1:0] seg_access;
   logic [ADDR_W-1:0]   fault_addr;

   modport source (
      output valid, func, seg_index, seg_base, seg_mem_bytes, seg_file_bytes,
             seg_file_start, seg_access, fault_addr,
      input  ready
   );

   modport sink (
      input  valid, func, seg_index, seg_base, seg_mem_bytes, seg_file_bytes,
             seg_file_start, seg_access, fault_addr,
      output ready
   );
endinterface

interface dpfr_rsp_if;
   import dpfr_pkg::*;

   logic                valid;
   logic                ready;
   outcome_type         outcome;
   logic [ADDR_W-1:0]   page_addr;
   logic [ADDR_W-1:0]   file_pos;
   logic [COPY_W-1:0]   copy_bytes;
   logic [ACCESS_W-1:0] page_access;

   modport source (
      output valid, outcome, page_addr, file_pos, copy_bytes, page_access,
      input  ready
   );

   modport sink (
      input  valid, outcome, page_addr, file_pos, copy_bytes, page_access,
      output ready
   );
endinterface

`default_nettype wire

// ===== hdl/demand_paging_fault_resolver.sv =====
// Top level of the demand paging fault resolver: segment table, sequencer and result register
//
// Usage:
//   req_if carries one transaction per item: func selects a segment load or a fault
//   resolve. rsp_if returns exactly one transaction per accepted item, in order.
//   csr_we/csr_wdata write segment_count, the number of table entries searched;
//   write it only while the block is idle.
// Sequencing and throughput:
//   A load, or a fault with segment_count zero, goes from acceptance straight to the
//   hand-off state and then into the output register. A fault passes the base compare
//   on a segment whose base lies above the address, and the base and size compares on
//   any other, then up to five more steps (file compare, bitmap read and page address,
//   file offset, bytes left, hand-off).
//   req_if.ready is high only while the sequencer is idle, to which it returns as a
//   response is loaded into the output register.
// Reset:
//   Synchronous reset clears the segment table, all row-valid bits of the mapped
//   bitmap (so every page reads as unmapped), segment_count and the response valid.
// Stall:
//   A finished response is held in the output register until rsp_if.ready; the next
//   request is accepted meanwhile, and its result waits in the sequencer.
`default_nettype none
`include "demand_paging_fault_resolver_assert.svh"

module demand_paging_fault_resolver (
   input  logic                        clock,
   input  logic                        reset,
   dpfr_req_if.sink                    req_if,
   dpfr_rsp_if.source                  rsp_if,
   input  logic                        csr_we,
   input  logic [dpfr_pkg::CSR_W-1:0]  csr_wdata
);
   import dpfr_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_BASE,
      S_LIMIT,
      S_PAGE,
      S_BIT,
      S_FPOS,
      S_LEFT,
      S_RESP
   } state_type;

   state_type           state_ff, state_in;
   logic [CSR_W-1:0]    seg_count_ff;
   logic [CNT_W-1:0]    seg_ff, seg_in;
   logic [CNT_W-1:0]    lim_ff, lim_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [ADDR_W-1:0]   off_ff, off_in;
   logic                has_file_ff, has_file_in;
   logic [MAX_SEGMENTS-1:0] row_valid_ff, row_valid_in;

   outcome_type         res_outcome_ff, res_outcome_in;
   logic [ADDR_W-1:0]   res_page_addr_ff, res_page_addr_in;
   logic [ADDR_W-1:0]   res_file_pos_ff, res_file_pos_in;
   logic [COPY_W-1:0]   res_copy_ff, res_copy_in;
   logic [ACCESS_W-1:0] res_access_ff, res_access_in;

   logic                rsp_valid_ff, rsp_valid_in;
   outcome_type         rsp_outcome_ff, rsp_outcome_in;
   logic [ADDR_W-1:0]   rsp_page_addr_ff, rsp_page_addr_in;
   logic [ADDR_W-1:0]   rsp_file_pos_ff, rsp_file_pos_in;
   logic [COPY_W-1:0]   rsp_copy_ff, rsp_copy_in;
   logic [ACCESS_W-1:0] rsp_access_ff, rsp_access_in;

   logic [ADDR_W-1:0]   base_tbl_ff       [MAX_SEGMENTS];
   logic [ADDR_W-1:0]   mem_size_tbl_ff   [MAX_SEGMENTS];
   logic [ADDR_W-1:0]   file_size_tbl_ff  [MAX_SEGMENTS];
   logic [ADDR_W-1:0]   file_start_tbl_ff [MAX_SEGMENTS];
   logic [ACCESS_W-1:0] access_tbl_ff     [MAX_SEGMENTS];

   logic                req_accept;
   logic                load_wr;
   logic [SEG_W-1:0]    wr_sel;
   logic [SEG_W-1:0]    seg_sel;
   logic [CNT_W-1:0]    seg_next;
   logic [CNT_W-1:0]    lim_new;
   logic [ADDR_W-1:0]   page_off;
   logic [PAGE_W-1:0]   page_idx;
   logic                over_capacity;
   logic [ROW_W-1:0]    row_cur;
   logic [ADDR_W-1:0]   copy_full;

   alu_req_type         alu_req;
   alu_rsp_type         alu_rsp;
   logic                map_rd_en;
   logic [ROW_W-1:0]    map_rd_data;
   map_wr_type          map_wr;

   dpfr_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   dpfr_map_ram u_map_ram (
      .clock   (clock),
      .rd_en   (map_rd_en),
      .rd_row  (seg_sel),
      .rd_data (map_rd_data),
      .wr      (map_wr)
   );

   assign req_accept = req_if.valid && req_if.ready;
   assign load_wr    = req_accept && (req_if.func == FUNC_LOAD)
                       && (32'(req_if.seg_index) < MAX_SEGMENTS);
   assign wr_sel     = SEG_W'(req_if.seg_index);
   assign seg_sel    = seg_ff[SEG_W-1:0];
   assign seg_next   = seg_ff + CNT_W'(1);
   assign lim_new    = (32'(seg_count_ff) > MAX_SEGMENTS) ? CNT_W'(MAX_SEGMENTS)
                                                          : CNT_W'(seg_count_ff);
   assign page_off   = off_ff & ~ADDR_W'(PAGE_BYTES - 1);
   assign page_idx   = PAGE_W'(off_ff >> PAGE_SHIFT);
   assign over_capacity = (32'(off_ff >> PAGE_SHIFT) >= PAGES_PER_SEGMENT);
   assign row_cur    = row_valid_ff[seg_sel] ? map_rd_data : '0;
   assign copy_full  = (alu_rsp.sum >> PAGE_SHIFT) != '0 ? ADDR_W'(PAGE_BYTES) : alu_rsp.sum;

   always_comb begin
      state_in         = state_ff;
      seg_in           = seg_ff;
      lim_in           = lim_ff;
      addr_in          = addr_ff;
      off_in           = off_ff;
      has_file_in      = has_file_ff;
      row_valid_in     = row_valid_ff;
      res_outcome_in   = res_outcome_ff;
      res_page_addr_in = res_page_addr_ff;
      res_file_pos_in  = res_file_pos_ff;
      res_copy_in      = res_copy_ff;
      res_access_in    = res_access_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_if.ready;
      rsp_outcome_in   = rsp_outcome_ff;
      rsp_page_addr_in = rsp_page_addr_ff;
      rsp_file_pos_in  = rsp_file_pos_ff;
      rsp_copy_in      = rsp_copy_ff;
      rsp_access_in    = rsp_access_ff;
      alu_req.op       = ALU_SUB;
      alu_req.a        = addr_ff;
      alu_req.b        = base_tbl_ff[seg_sel];
      map_rd_en        = 1'b0;
      map_wr.en        = 1'b0;
      map_wr.row       = seg_sel;
      map_wr.data      = row_cur | (ROW_W'(1) << page_idx);

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               res_page_addr_in = '0;
               res_file_pos_in  = '0;
               res_copy_in      = '0;
               res_access_in    = '0;
               if (req_if.func == FUNC_LOAD) begin
                  res_outcome_in = OUT_LOADED;
                  if (load_wr) begin
                     row_valid_in[wr_sel] = 1'b0;
                  end
                  state_in = S_RESP;
               end else begin
                  res_outcome_in = OUT_FORWARD;
                  addr_in        = req_if.fault_addr;
                  seg_in         = '0;
                  lim_in         = lim_new;
                  state_in       = (lim_new == '0) ? S_RESP : S_BASE;
               end
            end
         end
         S_BASE: begin
            off_in = alu_rsp.sum;
            if (alu_rsp.borrow) begin
               seg_in   = seg_next;
               state_in = (seg_next == lim_ff) ? S_RESP : S_BASE;
            end else begin
               state_in = S_LIMIT;
            end
         end
         S_LIMIT: begin
            alu_req.a = off_ff;
            alu_req.b = mem_size_tbl_ff[seg_sel];
            if (alu_rsp.borrow) begin
               state_in = S_PAGE;
            end else begin
               seg_in   = seg_next;
               state_in = (seg_next == lim_ff) ? S_RESP : S_BASE;
            end
         end
         S_PAGE: begin
            alu_req.a   = off_ff;
            alu_req.b   = file_size_tbl_ff[seg_sel];
            has_file_in = alu_rsp.borrow;
            if (over_capacity) begin
               state_in = S_RESP;
            end else begin
               map_rd_en = 1'b1;
               state_in  = S_BIT;
            end
         end
         S_BIT: begin
            alu_req.op = ALU_ADD;
            alu_req.a  = base_tbl_ff[seg_sel];
            alu_req.b  = page_off;
            if (row_cur[page_idx]) begin
               res_outcome_in = OUT_MAPPED;
               state_in       = S_RESP;
            end else begin
               res_outcome_in        = OUT_MAP;
               res_page_addr_in      = alu_rsp.sum;
               res_access_in         = access_tbl_ff[seg_sel];
               map_wr.en             = 1'b1;
               row_valid_in[seg_sel] = 1'b1;
               state_in              = has_file_ff ? S_FPOS : S_RESP;
            end
         end
         S_FPOS: begin
            alu_req.op      = ALU_ADD;
            alu_req.a       = file_start_tbl_ff[seg_sel];
            alu_req.b       = page_off;
            res_file_pos_in = alu_rsp.sum;
            state_in        = S_LEFT;
         end
         S_LEFT: begin
            alu_req.a   = file_size_tbl_ff[seg_sel];
            alu_req.b   = page_off;
            res_copy_in = copy_full[COPY_W-1:0];
            state_in    = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in     = 1'b1;
               rsp_outcome_in   = res_outcome_ff;
               rsp_page_addr_in = res_page_addr_ff;
               rsp_file_pos_in  = res_file_pos_ff;
               rsp_copy_in      = res_copy_ff;
               rsp_access_in    = res_access_ff;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         seg_count_ff <= '0;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            seg_count_ff <= csr_wdata;
         end
      end
      seg_ff           <= seg_in;
      lim_ff           <= lim_in;
      addr_ff          <= addr_in;
      off_ff           <= off_in;
      has_file_ff      <= has_file_in;
      res_outcome_ff   <= res_outcome_in;
      res_page_addr_ff <= res_page_addr_in;
      res_file_pos_ff  <= res_file_pos_in;
      res_copy_ff      <= res_copy_in;
      res_access_ff    <= res_access_in;
      rsp_outcome_ff   <= rsp_outcome_in;
      rsp_page_addr_ff <= rsp_page_addr_in;
      rsp_file_pos_ff  <= rsp_file_pos_in;
      rsp_copy_ff      <= rsp_copy_in;
      rsp_access_ff    <= rsp_access_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_SEGMENTS; k++) begin
            base_tbl_ff[k]       <= '0;
            mem_size_tbl_ff[k]   <= '0;
            file_size_tbl_ff[k]  <= '0;
            file_start_tbl_ff[k] <= '0;
            access_tbl_ff[k]     <= '0;
         end
      end else if (load_wr) begin
         base_tbl_ff[wr_sel]       <= req_if.seg_base;
         mem_size_tbl_ff[wr_sel]   <= req_if.seg_mem_bytes;
         file_size_tbl_ff[wr_sel]  <= req_if.seg_file_bytes;
         file_start_tbl_ff[wr_sel] <= req_if.seg_file_start;
         access_tbl_ff[wr_sel]     <= req_if.seg_access;
      end
   end

   assign req_if.ready       = (state_ff == S_IDLE);
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.outcome     = rsp_outcome_ff;
   assign rsp_if.page_addr   = rsp_page_addr_ff;
   assign rsp_if.file_pos    = rsp_file_pos_ff;
   assign rsp_if.copy_bytes  = rsp_copy_ff;
   assign rsp_if.page_access = rsp_access_ff;

   `DPFR_ASSERT_NEXT(a_busy_after_accept, req_accept, !req_if.ready,
      "sequencer accepted a transaction but stayed ready")
   `DPFR_ASSERT_SAME(a_fields_zero_unless_map,
      rsp_if.valid && (rsp_if.outcome != OUT_MAP),
      (rsp_if.page_addr == '0) && (rsp_if.copy_bytes == '0) && (rsp_if.page_access == '0),
      "response fields set on a non-map outcome")
   `DPFR_ASSERT_SAME(a_zero_fill_no_pos, rsp_if.valid && (rsp_if.copy_bytes == '0),
      rsp_if.file_pos == '0, "file position set on a zero-fill response")
   `DPFR_ASSERT_SAME(a_copy_within_page, rsp_if.valid,
      32'(rsp_if.copy_bytes) <= PAGE_BYTES, "copy length exceeds page size")
   `DPFR_ASSERT_NEXT(a_row_valid_after_write, map_wr.en,
      row_valid_ff[$past(map_wr.row)], "bitmap row written but not marked valid")

endmodule

`default_nettype wire

// ===== hdl/dpfr_alu.sv =====
// Shared 32-bit add/subtract unit with borrow out
`default_nettype none

module dpfr_alu (
   input  dpfr_pkg::alu_req_type req,
   output dpfr_pkg::alu_rsp_type rsp
);
   import dpfr_pkg::*;

   logic [ADDR_W:0]   total;
   logic [ADDR_W-1:0] operand_b;
   logic              is_sub;

   assign is_sub    = (req.op == ALU_SUB);
   assign operand_b = is_sub ? ~req.b : req.b;
   assign total     = {1'b0, req.a} + {1'b0, operand_b} + {{ADDR_W{1'b0}}, is_sub};

   assign rsp.sum    = total[ADDR_W-1:0];
   assign rsp.borrow = is_sub & ~total[ADDR_W];

endmodule

`default_nettype wire

// ===== hdl/dpfr_map_ram.sv =====
// Mapped-page bitmap memory, one row of page bits per segment, registered read
`default_nettype none

module dpfr_map_ram (
   input  logic                        clock,
   input  logic                        rd_en,
   input  logic [dpfr_pkg::SEG_W-1:0]  rd_row,
   output logic [dpfr_pkg::ROW_W-1:0]  rd_data,
   input  dpfr_pkg::map_wr_type        wr
);
   import dpfr_pkg::*;

   logic [ROW_W-1:0] rows [MAX_SEGMENTS];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         rows[wr.row] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= rows[rd_row];
      end
   end

endmodule

`default_nettype wire

// ===== sim/tb_demand_paging_fault_resolver.sv =====
// Testbench of the demand paging fault resolver: directed and random transactions
module tb_demand_paging_fault_resolver;
   import dpfr_pkg::*;

   typedef struct packed {
      logic                func;
      logic [IDX_W-1:0]    seg_index;
      logic [ADDR_W-1:0]   seg_base;
      logic [ADDR_W-1:0]   seg_mem_bytes;
      logic [ADDR_W-1:0]   seg_file_bytes;
      logic [ADDR_W-1:0]   seg_file_start;
      logic [ACCESS_W-1:0] seg_access;
      logic [ADDR_W-1:0]   fault_addr;
   } page_request_type;

   typedef struct packed {
      outcome_type         outcome;
      logic [ADDR_W-1:0]   page_addr;
      logic [ADDR_W-1:0]   file_pos;
      logic [COPY_W-1:0]   copy_bytes;
      logic [ACCESS_W-1:0] page_access;
   } page_result_type;

   class fault_ledger;
      bit [CSR_W-1:0]    segment_count;
      bit [ADDR_W-1:0]   base_tbl [MAX_SEGMENTS];
      bit [ADDR_W-1:0]   mem_tbl [MAX_SEGMENTS];
      bit [ADDR_W-1:0]   file_tbl [MAX_SEGMENTS];
      bit [ADDR_W-1:0]   start_tbl [MAX_SEGMENTS];
      bit [ACCESS_W-1:0] access_tbl [MAX_SEGMENTS];
      bit                mapped [MAX_SEGMENTS][PAGES_PER_SEGMENT];
      page_result_type   awaited [$];
      int                mismatches;
      int                outcome_seen [4];

      function page_result_type resolve(page_request_type r);
         page_result_type res;
         int unsigned  lim;
         int unsigned  page;
         bit [ADDR_W-1:0] off;
         bit [ADDR_W-1:0] page_off;
         bit [ADDR_W-1:0] left;
         res = '0;
         res.outcome = OUT_LOADED;
         if (r.func == FUNC_LOAD) begin
            base_tbl[r.seg_index]   = r.seg_base;
            mem_tbl[r.seg_index]    = r.seg_mem_bytes;
            file_tbl[r.seg_index]   = r.seg_file_bytes;
            start_tbl[r.seg_index]  = r.seg_file_start;
            access_tbl[r.seg_index] = r.seg_access;
            for (int p = 0; p < PAGES_PER_SEGMENT; p++) mapped[r.seg_index][p] = 1'b0;
            return res;
         end
         lim = (segment_count > MAX_SEGMENTS) ? MAX_SEGMENTS : segment_count;
         res.outcome = OUT_FORWARD;
         for (int i = 0; i < lim; i++) begin
            if (base_tbl[i] > r.fault_addr) continue;
            off = r.fault_addr - base_tbl[i];
            if (off >= mem_tbl[i]) continue;
            page = off / PAGE_BYTES;
            if (page >= PAGES_PER_SEGMENT) return res;
            if (mapped[i][page]) begin
               res.outcome = OUT_MAPPED;
               return res;
            end
            page_off = page * PAGE_BYTES;
            res.outcome = OUT_MAP;
            res.page_addr = base_tbl[i] + page_off;
            if (off < file_tbl[i]) begin
               left = file_tbl[i] - page_off;
               res.copy_bytes = COPY_W'((left < PAGE_BYTES) ? left : PAGE_BYTES);
               res.file_pos = start_tbl[i] + page_off;
            end
            res.page_access = access_tbl[i];
            mapped[i][page] = 1'b1;
            return res;
         end
         return res;
      endfunction

      function void note_request(page_request_type r);
         awaited.push_back(resolve(r));
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(page_result_type got);
         page_result_type want;
         if (awaited.size() == 0) begin
            $display("%0t: response with no transaction pending: expected none, actual %h",
                     $time, got);
            mismatches++;
            return;
         end
         want = awaited.pop_front();
         outcome_seen[int'(want.outcome)]++;
         compare_field("outcome", 32'(want.outcome), 32'(got.outcome));
         compare_field("page_addr", want.page_addr, got.page_addr);
         compare_field("file_pos", want.file_pos, got.file_pos);
         compare_field("copy_bytes", 32'(want.copy_bytes), 32'(got.copy_bytes));
         compare_field("page_access", 32'(want.page_access), 32'(got.page_access));
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_we;
   logic [CSR_W-1:0] csr_wdata;
   bit               steady;
   int unsigned      items_sent;
   bit [ADDR_W-1:0]  aim_base [MAX_SEGMENTS];
   bit [ADDR_W-1:0]  aim_mem [MAX_SEGMENTS];
   fault_ledger      ledger = new;

   dpfr_req_if req_bus();
   dpfr_rsp_if rsp_bus();

   demand_paging_fault_resolver uut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   initial begin
      #20000000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      page_result_type got;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got.outcome     = rsp_bus.outcome;
            got.page_addr   = rsp_bus.page_addr;
            got.file_pos    = rsp_bus.file_pos;
            got.copy_bytes  = rsp_bus.copy_bytes;
            got.page_access = rsp_bus.page_access;
            ledger.check_response(got);
         end
         rsp_bus.ready <= !reset && (steady || $urandom_range(99) >= 17);
      end
   end

   function automatic page_request_type load_item(logic [IDX_W-1:0] idx, logic [31:0] base,
                                                  logic [31:0] mem, logic [31:0] file,
                                                  logic [31:0] start, logic [2:0] acc);
      page_request_type r;
      r.func           = FUNC_LOAD;
      r.seg_index      = idx;
      r.seg_base       = base;
      r.seg_mem_bytes  = mem;
      r.seg_file_bytes = file;
      r.seg_file_start = start;
      r.seg_access     = acc;
      r.fault_addr     = $urandom;
      aim_base[idx]    = base;
      aim_mem[idx]     = mem;
      return r;
   endfunction

   function automatic page_request_type fault_item(logic [31:0] addr);
      page_request_type r;
      r.func           = FUNC_FAULT;
      r.seg_index      = IDX_W'($urandom);
      r.seg_base       = $urandom;
      r.seg_mem_bytes  = $urandom;
      r.seg_file_bytes = $urandom;
      r.seg_file_start = $urandom;
      r.seg_access     = ACCESS_W'($urandom);
      r.fault_addr     = addr;
      return r;
   endfunction

   function automatic page_request_type random_item();
      int unsigned pick;
      int unsigned idx;
      int unsigned span;
      logic [31:0] base;
      logic [31:0] mem;
      logic [31:0] file;
      pick = $urandom_range(99);
      idx  = $urandom_range(MAX_SEGMENTS - 1);
      if (pick < 12) begin
         base = $urandom;
         if ($urandom_range(3) != 0) base[11:0] = '0;
         if ($urandom_range(4) == 0)
            base = aim_base[$urandom_range(MAX_SEGMENTS - 1)] + $urandom_range(0, 8 * PAGE_BYTES);
         case ($urandom_range(9))
            0: mem = '0;
            1: mem = $urandom;
            default: mem = $urandom_range(1, 300 * PAGE_BYTES);
         endcase
         case ($urandom_range(9))
            0, 1: file = '0;
            2, 3: file = $urandom;
            4: file = mem;
            default: file = $urandom_range(0, mem);
         endcase
         return load_item(IDX_W'(idx), base, mem, file, $urandom, 3'($urandom_range(7)));
      end
      if (pick < 22) return fault_item($urandom);
      if (aim_mem[idx] == 0) span = 0;
      else if (aim_mem[idx] > 300 * PAGE_BYTES) span = 300 * PAGE_BYTES;
      else span = aim_mem[idx] - 1;
      return fault_item(aim_base[idx] + $urandom_range(0, span));
   endfunction

   task automatic send_item(input page_request_type r);
      while (!steady && $urandom_range(99) < 17) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.func           <= r.func;
      req_bus.seg_index      <= r.seg_index;
      req_bus.seg_base       <= r.seg_base;
      req_bus.seg_mem_bytes  <= r.seg_mem_bytes;
      req_bus.seg_file_bytes <= r.seg_file_bytes;
      req_bus.seg_file_start <= r.seg_file_start;
      req_bus.seg_access     <= r.seg_access;
      req_bus.fault_addr     <= r.fault_addr;
      do @(posedge clock); while (!req_bus.ready);
      ledger.note_request(r);
      items_sent++;
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (ledger.awaited.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_segment_count(input logic [CSR_W-1:0] value);
      settle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      ledger.segment_count = value;
   endtask

   initial begin
      int unsigned      phase_items [6];
      logic [CSR_W-1:0] phase_count [6];
      phase_items            = '{400, 300, 300, 100, 400, 300};
      req_bus.valid          <= 1'b0;
      req_bus.func           <= FUNC_LOAD;
      req_bus.seg_index      <= '0;
      req_bus.seg_base       <= '0;
      req_bus.seg_mem_bytes  <= '0;
      req_bus.seg_file_bytes <= '0;
      req_bus.seg_file_start <= '0;
      req_bus.seg_access     <= '0;
      req_bus.fault_addr     <= '0;
      csr_we                 <= 1'b0;
      csr_wdata              <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // no segments searched yet: forward
      send_item(fault_item(32'h0000_0000));
      write_segment_count(CSR_W'(MAX_SEGMENTS));
      send_item(load_item(0, 32'h0000_1000, 32'h0000_3800, 32'h0000_2100, 32'h0000_0200, 5));
      send_item(load_item(1, 32'hFFFF_F000, '1, '1, '1, 7));
      send_item(load_item(2, 32'h0001_0000, 32'h0020_0000, '0, 32'h0000_1234, 3));
      send_item(load_item(3, '0, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_F000, 6));
      send_item(load_item(4, '0, '0, '0, '0, 0));
      send_item(load_item(7, 32'h8000_0000, '0, '1, '1, 0));
      send_item(fault_item(32'h0000_1ABC));
      send_item(fault_item(32'h0000_1000));
      send_item(fault_item(32'h0000_3000));
      send_item(fault_item(32'h0000_4700));
      send_item(fault_item(32'h0000_4800));
      send_item(fault_item(32'hFFFF_FFFF));
      send_item(fault_item(32'h0010_FFFF));
      send_item(fault_item(32'h0011_0000));
      send_item(fault_item(32'h8000_0000));
      send_item(fault_item(32'h0000_0000));
      send_item(load_item(0, 32'h0000_1000, 32'h0000_3800, 32'h0000_2100, 32'h0000_0200, 5));
      send_item(fault_item(32'h0000_1000));
      write_segment_count('1);
      send_item(fault_item(32'hFFFF_FFFF));
      write_segment_count(CSR_W'(1));
      send_item(fault_item(32'h0000_4800));

      phase_count = '{CSR_W'(MAX_SEGMENTS), '1, CSR_W'(3), '0, CSR_W'(MAX_SEGMENTS),
                      CSR_W'($urandom_range(15))};
      for (int ph = 0; ph < 6; ph++) begin
         write_segment_count(phase_count[ph]);
         steady = (ph == 4);
         repeat (phase_items[ph]) send_item(random_item());
         steady = 1'b0;
      end

      settle();
      $display("Covered %0d transactions: %0d loads, %0d pages mapped, %0d forwarded, %0d repeats",
               items_sent, ledger.outcome_seen[int'(OUT_LOADED)],
               ledger.outcome_seen[int'(OUT_MAP)], ledger.outcome_seen[int'(OUT_FORWARD)],
               ledger.outcome_seen[int'(OUT_MAPPED)]);
      $display("Segment counts used: 0, 1, 3, 8, 15 and %0d", phase_count[5]);
      if (ledger.mismatches == 0 && ledger.awaited.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
